@@ sv/sqv_pkg.sv @@
package sqv_pkg;

    localparam int POS_W       = 24;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TINT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEF_AMP  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEF_FREQ = 2'd2;

    localparam logic [31:0] WHITE_RGBA = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        [31:0] tint;
        logic signed [15:0] def_amp;
        logic signed [15:0] def_freq;
    } cfg_t;

    // sprite command as held in the input register
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] size_x;
        logic signed [POS_W-1:0] size_y;
        logic        [15:0]      rotation_angle;
        logic        [31:0]      uv_min;
        logic        [31:0]      uv_max;
        logic        [31:0]      color_rgba;
        logic signed [15:0]      layer;
        logic signed [15:0]      pulse_amplitude;
        logic signed [15:0]      pulse_frequency;
        logic                    has_material;
    } cmd_t;

    // per-quad values shared by all four corners
    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W+1:0] cx2;
        logic signed [POS_W+1:0] cy2;
        logic signed [40:0]      sx_cos;
        logic signed [40:0]      sx_sin;
        logic signed [40:0]      sy_cos;
        logic signed [40:0]      sy_sin;
        logic                    rotate;
        logic        [15:0]      umin;
        logic        [15:0]      umax;
        logic        [15:0]      vmin;
        logic        [15:0]      vmax;
        logic signed [15:0]      z;
        logic        [31:0]      rgba;
        logic        [14:0]      amp;
        logic        [14:0]      freq;
    } quad_t;

    typedef struct packed {
        logic signed [POS_W-1:0] vertex_x;
        logic signed [POS_W-1:0] vertex_y;
        logic signed [15:0]      vertex_z;
        logic        [31:0]      tinted_rgba;
        logic        [15:0]      tex_u;
        logic        [15:0]      tex_v;
        logic        [14:0]      amplitude_out;
        logic        [14:0]      frequency_out;
        logic                    last_vertex;
    } vertex_t;

endpackage

@@ sv/sqv_sine_rom.sv @@
module sqv_sine_rom #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                                    aclk,
    input  logic                                    rd_en,
    input  logic [$clog2(SINE_TABLE_ENTRIES+1)-1:0] addr_a,
    input  logic [$clog2(SINE_TABLE_ENTRIES+1)-1:0] addr_b,
    output logic [14:0]                             data_a,
    output logic [14:0]                             data_b
);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    logic [14:0] rom_const [0:SINE_TABLE_ENTRIES];
    logic [14:0] data_a_reg;
    logic [14:0] data_b_reg;

    // quarter-wave table, 30 fraction bit Taylor series, built at elaboration
    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_entry
        localparam logic [63:0] X   = (PI_Q30 * 64'(k)) / (64'd2 * 64'(SINE_TABLE_ENTRIES));
        localparam logic [63:0] X2  = (X * X) >> 30;
        localparam logic [63:0] T1  = ((X   * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2  = ((T1  * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3  = ((T2  * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4  = ((T3  * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5  = ((T4  * X2) >> 30) / 64'd110;
        localparam logic [63:0] T6  = ((T5  * X2) >> 30) / 64'd156;
        localparam logic [63:0] T7  = ((T6  * X2) >> 30) / 64'd210;
        localparam logic [63:0] T8  = ((T7  * X2) >> 30) / 64'd272;
        localparam logic [63:0] T9  = ((T8  * X2) >> 30) / 64'd342;
        localparam logic [63:0] T10 = ((T9  * X2) >> 30) / 64'd420;
        localparam logic [63:0] T11 = ((T10 * X2) >> 30) / 64'd506;
        localparam logic [63:0] T12 = ((T11 * X2) >> 30) / 64'd600;
        localparam logic [63:0] POS = X + T2 + T4 + T6 + T8 + T10 + T12;
        localparam logic [63:0] NEG = T1 + T3 + T5 + T7 + T9 + T11;
        localparam logic [63:0] SUM = (POS > NEG) ? (POS - NEG) : 64'd0;
        localparam logic [63:0] RND = (SUM * 64'd32768 + 64'd536870912) >> 30;
        localparam logic [63:0] RV  = (RND > 64'd32767) ? 64'd32767 : RND;
        assign rom_const[k] = RV[14:0];
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_a_reg <= rom_const[addr_a];
            data_b_reg <= rom_const[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

@@ sv/sqv_item_stage.sv @@
module sqv_item_stage #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  sqv_pkg::cfg_t  cfg,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  sqv_pkg::cmd_t  cmd,
    output logic           quad_valid,
    input  logic           quad_ready,
    output sqv_pkg::quad_t quad
);

    localparam int AW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam logic [AW-1:0] FULL_INDEX  = AW'(SINE_TABLE_ENTRIES);
    localparam logic [15:0]   DEPTH_RECIP = 16'd33554;   // floor(2^22 / 125)
    localparam logic [15:0]   LAYER_LIMIT = 16'd16000;   // 1000.0 in Q11.4

    function automatic logic [AW-1:0] rom_addr(input logic [15:0] angle);
        logic [31:0]   scaled;
        logic [AW-1:0] idx;
        scaled = (32'(angle[13:0]) * 32'(SINE_TABLE_ENTRIES)) >> 14;
        idx    = scaled[AW-1:0];
        return angle[14] ? FULL_INDEX - idx : idx;
    endfunction

    // ---------------- stage 1: table read, tint products, depth estimate, pulse defaults
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               s1_load;
    logic               s2_adv;
    sqv_pkg::cmd_t      s1_cmd_reg;
    logic               s1_sin_neg_reg;
    logic               s1_cos_neg_reg;
    logic [15:0]        s1_prod_reg [4];
    logic [21:0]        s1_zu_reg;
    logic [15:0]        s1_zq0_reg;
    logic               s1_zneg_reg;
    logic [14:0]        s1_amp_reg;
    logic [14:0]        s1_freq_reg;

    logic [15:0]        cos_angle;
    logic [AW-1:0]      sin_addr;
    logic [AW-1:0]      cos_addr;
    logic [14:0]        sin_mag;
    logic [14:0]        cos_mag;
    logic [31:0]        tint;
    logic [15:0]        prod_next [4];
    logic               layer_neg;
    logic [15:0]        layer_abs;
    logic [13:0]        layer_mag;
    logic [21:0]        zu_next;
    logic [37:0]        zprod;
    logic signed [15:0] amp_sel;
    logic signed [15:0] freq_sel;
    logic [14:0]        amp_next;
    logic [14:0]        freq_next;

    assign s2_adv    = s1_valid_reg && (!s2_valid_reg || quad_ready);
    assign cmd_ready = !s1_valid_reg || s2_adv;
    assign s1_load   = cmd_valid && cmd_ready;

    assign cos_angle = cmd.rotation_angle + 16'd16384;
    assign sin_addr  = rom_addr(cmd.rotation_angle);
    assign cos_addr  = rom_addr(cos_angle);

    sqv_sine_rom #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_rom (
        .aclk   (aclk),
        .rd_en  (s1_load),
        .addr_a (sin_addr),
        .addr_b (cos_addr),
        .data_a (sin_mag),
        .data_b (cos_mag)
    );

    always_comb begin
        tint = cmd.has_material ? cfg.tint : sqv_pkg::WHITE_RGBA;
        for (int ch = 0; ch < 4; ch++) begin
            // c*t + 128 = (c*t + 127) + 1, ready for the /255 step
            prod_next[ch] = 16'(cmd.color_rgba[8*ch +: 8]) * 16'(tint[8*ch +: 8]) + 16'd128;
        end

        layer_neg = cmd.layer < 16'sd0;
        layer_abs = layer_neg ? 16'(-cmd.layer) : 16'(cmd.layer);
        layer_mag = (layer_abs > LAYER_LIMIT) ? LAYER_LIMIT[13:0] : layer_abs[13:0];
        // (2048a + 500) / 1000 == ((512a + 125) >> 1) / 125
        zu_next   = {layer_mag, 8'd0} + 22'd62;
        zprod     = 38'(zu_next) * 38'(DEPTH_RECIP);

        amp_sel  = (cmd.has_material && cmd.pulse_amplitude <= 16'sd0) ?
                   cfg.def_amp : cmd.pulse_amplitude;
        freq_sel = (cmd.has_material && cmd.pulse_frequency <= 16'sd0) ?
                   cfg.def_freq : cmd.pulse_frequency;
        if (amp_sel < 16'sd0) begin
            amp_next = 15'd0;
        end else if (amp_sel > 16'sd16384) begin
            amp_next = 15'd16384;
        end else begin
            amp_next = amp_sel[14:0];
        end
        freq_next = (freq_sel < 16'sd0) ? 15'd0 : freq_sel[14:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (cmd_ready) begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_cmd_reg     <= cmd;
            s1_sin_neg_reg <= cmd.rotation_angle[15];
            s1_cos_neg_reg <= cos_angle[15];
            s1_prod_reg    <= prod_next;
            s1_zu_reg      <= zu_next;
            s1_zq0_reg     <= zprod[37:22];
            s1_zneg_reg    <= layer_neg;
            s1_amp_reg     <= amp_next;
            s1_freq_reg    <= freq_next;
        end
    end

    // ---------------- stage 2: rotation products, /255, depth correction
    sqv_pkg::quad_t     quad_reg;
    sqv_pkg::quad_t     quad_next;
    logic signed [16:0] sin_v;
    logic signed [16:0] cos_v;
    logic [23:0]        scaled_ch [4];
    logic [23:0]        zrem;
    logic [16:0]        zq;

    always_comb begin
        sin_v = s1_sin_neg_reg ? -$signed({2'b00, sin_mag}) : $signed({2'b00, sin_mag});
        cos_v = s1_cos_neg_reg ? -$signed({2'b00, cos_mag}) : $signed({2'b00, cos_mag});

        quad_next.px     = s1_cmd_reg.pos_x;
        quad_next.py     = s1_cmd_reg.pos_y;
        quad_next.sx     = s1_cmd_reg.size_x;
        quad_next.sy     = s1_cmd_reg.size_y;
        quad_next.cx2    = (26'(s1_cmd_reg.pos_x) <<< 1) + 26'(s1_cmd_reg.size_x);
        quad_next.cy2    = (26'(s1_cmd_reg.pos_y) <<< 1) + 26'(s1_cmd_reg.size_y);
        quad_next.sx_cos = 41'(s1_cmd_reg.size_x) * 41'(cos_v);
        quad_next.sx_sin = 41'(s1_cmd_reg.size_x) * 41'(sin_v);
        quad_next.sy_cos = 41'(s1_cmd_reg.size_y) * 41'(cos_v);
        quad_next.sy_sin = 41'(s1_cmd_reg.size_y) * 41'(sin_v);
        quad_next.rotate = s1_cmd_reg.rotation_angle != 16'd0;
        quad_next.umin   = s1_cmd_reg.uv_min[31:16];
        quad_next.vmin   = s1_cmd_reg.uv_min[15:0];
        quad_next.umax   = s1_cmd_reg.uv_max[31:16];
        quad_next.vmax   = s1_cmd_reg.uv_max[15:0];

        // floor(x / 255) == (x + 1) * 257 >> 16 over this range
        for (int ch = 0; ch < 4; ch++) begin
            scaled_ch[ch]              = 24'(s1_prod_reg[ch]) * 24'd257;
            quad_next.rgba[8*ch +: 8] = scaled_ch[ch][23:16];
        end

        // estimate is exact or one low
        zrem = 24'(s1_zu_reg) - 24'(s1_zq0_reg) * 24'd125;
        zq   = (zrem >= 24'd125) ? 17'(s1_zq0_reg) + 17'd1 : 17'(s1_zq0_reg);
        if (s1_zneg_reg) begin
            quad_next.z = 16'(-$signed(zq));
        end else if (zq > 17'd32767) begin
            quad_next.z = 16'sd32767;
        end else begin
            quad_next.z = $signed(zq[15:0]);
        end

        quad_next.amp  = s1_amp_reg;
        quad_next.freq = s1_freq_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (!s2_valid_reg || quad_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            quad_reg <= quad_next;
        end
    end

    assign quad_valid = s2_valid_reg;
    assign quad       = quad_reg;

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_adv |=> s1_valid_reg)
        else $error("stage 1 word lost while stalled");

    a_quad_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        quad_valid && !quad_ready |=> quad_valid && $stable(quad_reg))
        else $error("quad word changed while held");

endmodule

@@ sv/sqv_corner_emit.sv @@
module sqv_corner_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             quad_valid,
    output logic             quad_ready,
    input  sqv_pkg::quad_t   quad,
    output logic             m_valid,
    input  logic             m_ready,
    output sqv_pkg::vertex_t vertex
);

    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_TL = 2'd3;

    function automatic logic signed [23:0] sat_pos(input logic signed [43:0] v);
        if (v > 44'sd8388607) begin
            return 24'sh7F_FFFF;
        end else if (v < -44'sd8388608) begin
            return 24'sh80_0000;
        end else begin
            return v[23:0];
        end
    endfunction

    logic             m_valid_reg;
    logic [1:0]       corner_reg;
    logic [1:0]       corner_next;
    sqv_pkg::vertex_t vertex_reg;
    sqv_pkg::vertex_t vertex_next;
    logic             out_free;
    logic             fire;
    logic             right;
    logic             bottom;
    logic signed [43:0] nx;
    logic signed [43:0] ny;
    logic signed [43:0] ex;
    logic signed [43:0] ey;

    assign out_free    = !m_valid_reg || m_ready;
    assign fire        = quad_valid && out_free;
    assign quad_ready  = out_free && (corner_reg == CORNER_TL);
    assign corner_next = corner_reg + 2'd1;

    always_comb begin
        // BL, BR, TR, TL
        right  = corner_reg[0] ^ corner_reg[1];
        bottom = !corner_reg[1];

        nx = (44'(quad.cx2) <<< 15)
           + (right  ? 44'(quad.sx_cos) : -44'(quad.sx_cos))
           - (bottom ? 44'(quad.sy_sin) : -44'(quad.sy_sin))
           + 44'sd32768;
        ny = (44'(quad.cy2) <<< 15)
           + (right  ? 44'(quad.sx_sin) : -44'(quad.sx_sin))
           + (bottom ? 44'(quad.sy_cos) : -44'(quad.sy_cos))
           + 44'sd32768;
        ex = right  ? 44'(quad.px) + 44'(quad.sx) : 44'(quad.px);
        ey = bottom ? 44'(quad.py) + 44'(quad.sy) : 44'(quad.py);

        if (quad.rotate) begin
            vertex_next.vertex_x = sat_pos(nx >>> 16);
            vertex_next.vertex_y = sat_pos(ny >>> 16);
        end else begin
            vertex_next.vertex_x = sat_pos(ex);
            vertex_next.vertex_y = sat_pos(ey);
        end
        vertex_next.vertex_z      = quad.z;
        vertex_next.tinted_rgba   = quad.rgba;
        vertex_next.tex_u         = right  ? quad.umax : quad.umin;
        vertex_next.tex_v         = bottom ? quad.vmax : quad.vmin;
        vertex_next.amplitude_out = quad.amp;
        vertex_next.frequency_out = quad.freq;
        vertex_next.last_vertex   = corner_reg == CORNER_TL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            corner_reg  <= CORNER_BL;
        end else begin
            if (out_free) begin
                m_valid_reg <= quad_valid;
            end
            if (fire) begin
                corner_reg <= corner_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            vertex_reg <= vertex_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign vertex  = vertex_reg;

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && corner_reg == CORNER_TL |=> m_valid_reg && vertex_reg.last_vertex)
        else $error("fourth corner word not marked last");

    a_quad_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && corner_reg != CORNER_TL |=> quad_valid)
        else $error("quad released before its fourth corner");

endmodule

@@ sv/sprite_quad_vertex_generator.sv @@
// An accepted command passes the input register, stage 1 and stage 2 before
// its first vertex word reaches m_*. The emitter gives one vertex word per
//   cycle while m_ready is high, four per command; its single output register
//   is the limit. Commands with a zero UV extent are accepted and emit nothing.
// Reset: synchronous, active low; clears all valid flags and the corner count
//   and loads the tint, amplitude and frequency registers with their defaults.
module sprite_quad_vertex_generator #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // command input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [23:0]                    s_pos_x,
    input  logic signed [23:0]                    s_pos_y,
    input  logic signed [23:0]                    s_size_x,
    input  logic signed [23:0]                    s_size_y,
    input  logic        [15:0]                    s_rotation_angle,
    input  logic        [31:0]                    s_uv_min,
    input  logic        [31:0]                    s_uv_max,
    input  logic        [31:0]                    s_color_rgba,
    input  logic signed [15:0]                    s_layer,
    input  logic signed [15:0]                    s_pulse_amplitude,
    input  logic signed [15:0]                    s_pulse_frequency,
    input  logic                                  s_has_material,

    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sqv_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [31:0]                           cfg_data,

    // vertex output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [23:0]                    m_vertex_x,
    output logic signed [23:0]                    m_vertex_y,
    output logic signed [15:0]                    m_vertex_z,
    output logic        [31:0]                    m_tinted_rgba,
    output logic        [15:0]                    m_tex_u,
    output logic        [15:0]                    m_tex_v,
    output logic        [14:0]                    m_amplitude_out,
    output logic        [14:0]                    m_frequency_out,
    output logic                                  m_last_vertex
);

    // Pipeline:
    //   input register -> stage 1 (sine table read, tint products, depth
    //   estimate, pulse defaults) -> stage 2 (rotation products, /255,
    //   depth correction) -> corner emitter, which walks BL, BR, TR, TL
    //   out of the held stage 2 word into the output register.
    // Each stage takes a new word whenever the one after it moves, so
    // a command can sit in the input register while the emitter is
    // still busy with the previous quad.

    sqv_pkg::cfg_t    cfg_reg;
    sqv_pkg::cmd_t    cmd_reg;
    sqv_pkg::quad_t   quad;
    sqv_pkg::vertex_t vertex;
    logic             s0_valid_reg;
    logic             cmd_ready;
    logic             quad_valid;
    logic             quad_ready;
    logic             degenerate;

    // ---------------- configuration registers
    // Writes are never stalled; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tint     <= sqv_pkg::WHITE_RGBA;
            cfg_reg.def_amp  <= 16'sd0;
            cfg_reg.def_freq <= 16'sd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sqv_pkg::CFG_TINT:     cfg_reg.tint     <= cfg_data;
                sqv_pkg::CFG_DEF_AMP:  cfg_reg.def_amp  <= $signed(cfg_data[15:0]);
                sqv_pkg::CFG_DEF_FREQ: cfg_reg.def_freq <= $signed(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // ---------------- input register
    // A command with an empty UV rectangle is taken but never marked valid.
    assign degenerate = (s_uv_min[31:16] == s_uv_max[31:16]) ||
                        (s_uv_min[15:0]  == s_uv_max[15:0]);
    assign s_ready    = !s0_valid_reg || cmd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s0_valid_reg <= s_valid && !degenerate;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg.pos_x           <= s_pos_x;
            cmd_reg.pos_y           <= s_pos_y;
            cmd_reg.size_x          <= s_size_x;
            cmd_reg.size_y          <= s_size_y;
            cmd_reg.rotation_angle  <= s_rotation_angle;
            cmd_reg.uv_min          <= s_uv_min;
            cmd_reg.uv_max          <= s_uv_max;
            cmd_reg.color_rgba      <= s_color_rgba;
            cmd_reg.layer           <= s_layer;
            cmd_reg.pulse_amplitude <= s_pulse_amplitude;
            cmd_reg.pulse_frequency <= s_pulse_frequency;
            cmd_reg.has_material    <= s_has_material;
        end
    end

    // ---------------- per-quad setup
    sqv_item_stage #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_item (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cmd_valid  (s0_valid_reg),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd_reg),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad)
    );

    // ---------------- corner walk and output register
    sqv_corner_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad       (quad),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .vertex     (vertex)
    );

    assign m_vertex_x      = vertex.vertex_x;
    assign m_vertex_y      = vertex.vertex_y;
    assign m_vertex_z      = vertex.vertex_z;
    assign m_tinted_rgba   = vertex.tinted_rgba;
    assign m_tex_u         = vertex.tex_u;
    assign m_tex_v         = vertex.tex_v;
    assign m_amplitude_out = vertex.amplitude_out;
    assign m_frequency_out = vertex.frequency_out;
    assign m_last_vertex   = vertex.last_vertex;

    a_drop_degenerate: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && degenerate |=> !s0_valid_reg)
        else $error("empty UV command entered the pipeline");

endmodule
